FILE: design/pss_pkg.sv
// package: types, codes and defaults for the positional sequence store
package pss_pkg;

  localparam int PSS_CAPACITY = 64;
  localparam int WORD_W       = 32;

  localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [2:0] MODE_POP_BACK   = 3'd3;
  localparam logic [2:0] MODE_INSERT     = 3'd4;
  localparam logic [2:0] MODE_ERASE      = 3'd5;
  localparam logic [2:0] MODE_QUERY      = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [2:0]               mode;
    logic [6:0]               position;
    logic signed [WORD_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] back_value;
    logic [6:0]               count;
    logic                     is_empty;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRIME,
    S_SHIFT,
    S_FILL,
    S_RD_FRONT,
    S_RD_BACK,
    S_RESULT
  } state_t;

endpackage

FILE: design/pss_ram.sv
// generic single-write, single-read ram with registered read data
module pss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/positional_sequence_store.sv
// top level: bounded ordered sequence with positional insert and erase
//
// Command channel: a request (mode, position, value) transfers at a rising
// edge where start is high and busy is low. busy stays high until the result
// has been shown. Result channel: done is high for exactly one cycle and the
// result (status, front and back values, count, empty flag) is valid in that
// cycle only; the receiver cannot stall it.
// Elements sit packed at the low end of one ram, entry 0 at the front. Insert
// and push open a gap by moving every element behind the position up one
// entry; erase and pop close it by moving them down. One element moves per
// cycle through the ram's read and write ports, after a priming read when any
// element moves; push and insert then write the new value. A new request can
// transfer in the cycle after done.
// Front and back are fetched from the ram after the move.
// Reset empties the list at once; no clearing pass over the ram is needed.
module positional_sequence_store #(
  parameter int CAPACITY = pss_pkg::PSS_CAPACITY
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  pss_pkg::request_t request,
  output logic              busy,
  output logic              done,
  output pss_pkg::result_t  result
);
  import pss_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > 7) ? CW : 7) + 1;

  state_t            state, state_next;
  logic              up, up_next;
  logic [AW-1:0]     ptr, ptr_next;
  logic [AW-1:0]     idx, idx_next;
  logic [CW-1:0]     rem, rem_next;
  logic [WORD_W-1:0] val, val_next;
  logic [1:0]        status, status_next;
  logic [CW-1:0]     count, count_next;
  logic [WORD_W-1:0] front, front_next;

  logic              grow, shrink;
  logic [PW-1:0]     cnt_ext, pos_ext, idx_w, rem_w;
  logic              full;
  logic [1:0]        status_dec;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [WORD_W-1:0] wdata, rdata;

  pss_ram #(
    .WIDTH(WORD_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    up     <= up_next;
    ptr    <= ptr_next;
    idx    <= idx_next;
    rem    <= rem_next;
    val    <= val_next;
    status <= status_next;
    front  <= front_next;
  end

  // command decode
  always_comb begin
    cnt_ext = PW'(count);
    pos_ext = PW'(request.position);
    full    = (count == CW'(CAPACITY));
    grow    = 1'b0;
    shrink  = 1'b0;
    idx_w   = '0;
    status_dec = ST_OK;
    case (request.mode)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (full) begin
          status_dec = ST_FULL;
        end else begin
          grow  = 1'b1;
          idx_w = (request.mode == MODE_PUSH_FRONT) ? '0 : cnt_ext;
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        if (count == '0) begin
          status_dec = ST_EMPTY;
        end else begin
          shrink = 1'b1;
          idx_w  = (request.mode == MODE_POP_FRONT) ? '0 : cnt_ext - PW'(1);
        end
      end
      MODE_INSERT: begin
        if (pos_ext == '0 || pos_ext > cnt_ext + PW'(1)) begin
          status_dec = ST_RANGE;
        end else if (full) begin
          status_dec = ST_FULL;
        end else begin
          grow  = 1'b1;
          idx_w = pos_ext - PW'(1);
        end
      end
      MODE_ERASE: begin
        if (pos_ext == '0 || pos_ext > cnt_ext) begin
          status_dec = ST_RANGE;
        end else begin
          shrink = 1'b1;
          idx_w  = pos_ext - PW'(1);
        end
      end
      default: begin
        status_dec = ST_OK;
      end
    endcase
    rem_w = grow ? (cnt_ext - idx_w) : (cnt_ext - PW'(1) - idx_w);
  end

  // sequencer
  always_comb begin
    state_next  = state;
    up_next     = up;
    ptr_next    = ptr;
    idx_next    = idx;
    rem_next    = rem;
    val_next    = val;
    status_next = status;
    count_next  = count;
    front_next  = front;
    we          = 1'b0;
    waddr       = ptr;
    wdata       = rdata;
    raddr       = '0;
    busy        = (state != S_IDLE);
    done        = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          status_next = status_dec;
          val_next    = request.value;
          up_next     = grow;
          idx_next    = idx_w[AW-1:0];
          rem_next    = rem_w[CW-1:0];
          ptr_next    = grow ? AW'(count) : idx_w[AW-1:0];
          if (grow) begin
            count_next = count + CW'(1);
            state_next = (rem_w == '0) ? S_FILL : S_PRIME;
          end else if (shrink) begin
            count_next = count - CW'(1);
            state_next = (rem_w == '0) ? S_RD_FRONT : S_PRIME;
          end else begin
            state_next = S_RD_FRONT;
          end
        end
      end
      S_PRIME: begin
        raddr      = up ? ptr - AW'(1) : ptr + AW'(1);
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        we       = 1'b1;
        waddr    = ptr;
        wdata    = rdata;
        ptr_next = up ? ptr - AW'(1) : ptr + AW'(1);
        rem_next = rem - CW'(1);
        raddr    = up ? ptr_next - AW'(1) : ptr_next + AW'(1);
        if (rem == CW'(1)) begin
          state_next = up ? S_FILL : S_RD_FRONT;
        end
      end
      S_FILL: begin
        we         = 1'b1;
        waddr      = idx;
        wdata      = val;
        state_next = S_RD_FRONT;
      end
      S_RD_FRONT: begin
        raddr      = '0;
        state_next = S_RD_BACK;
      end
      S_RD_BACK: begin
        front_next = rdata;
        raddr      = AW'(count - CW'(1));
        state_next = S_RESULT;
      end
      S_RESULT: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    result.status      = status;
    result.front_value = (count == '0) ? '0 : $signed(front);
    result.back_value  = (count == '0) ? '0 : $signed(rdata);
    result.count       = 7'(count);
    result.is_empty    = (count == '0);
  end

endmodule

FILE: tb/positional_sequence_store_tb.sv
`timescale 1ns / 100ps
// testbench for the positional sequence store: directed table, random phases, queue predictor
module positional_sequence_store_tb;
  import pss_pkg::*;

  localparam int         CAP           = PSS_CAPACITY;
  localparam int         SETTLE_CYCLES = PSS_CAPACITY + 10;
  localparam logic [2:0] MODE_UNUSED   = 3'd7;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fffffff;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh80000000;

  typedef struct packed {
    request_t req;
    logic     typed;
    result_t  want;
  } table_row_t;

  localparam result_t NO_RESULT = '0;

  logic     clk = 1'b0;
  logic     rst;
  logic     start;
  request_t request;
  logic     busy;
  logic     done;
  result_t  result;

  logic signed [WORD_W-1:0] held_words[$];
  result_t                  pending_results[$];
  table_row_t               directed_rows[$];
  int                       error_count = 0;
  int                       sender_idle_pct = 0;

  always #4 clk = ~clk;

  positional_sequence_store dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .request(request),
    .busy(busy),
    .done(done),
    .result(result)
  );

  task automatic note_error(input string what);
    $display("ERROR at %0t: %s", $time, what);
    error_count++;
  endtask

  function automatic request_t mk_req(input logic [2:0] m, input logic [6:0] p,
                                      input logic signed [WORD_W-1:0] v);
    request_t r;
    r.mode     = m;
    r.position = p;
    r.value    = v;
    return r;
  endfunction

  function automatic result_t mk_result(input logic [1:0] st,
                                        input logic signed [WORD_W-1:0] f,
                                        input logic signed [WORD_W-1:0] b,
                                        input logic [6:0] c, input logic e);
    result_t r;
    r.status      = st;
    r.front_value = f;
    r.back_value  = b;
    r.count       = c;
    r.is_empty    = e;
    return r;
  endfunction

  task automatic add_row(input request_t req, input logic typed, input result_t want);
    directed_rows.insert(directed_rows.size(), {req, typed, want});
  endtask

  function automatic result_t apply_request(input request_t r);
    result_t    res;
    logic [1:0] st;
    int         n;
    st = ST_OK;
    n  = held_words.size();
    case (r.mode)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (n >= CAP) st = ST_FULL;
        else if (r.mode == MODE_PUSH_FRONT) held_words.insert(0, r.value);
        else held_words.insert(n, r.value);
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        if (n == 0) st = ST_EMPTY;
        else if (r.mode == MODE_POP_FRONT) held_words.delete(0);
        else held_words.delete(n - 1);
      end
      MODE_INSERT: begin
        if (r.position == 0 || r.position > n + 1) st = ST_RANGE;
        else if (n >= CAP) st = ST_FULL;
        else held_words.insert(r.position - 1, r.value);
      end
      MODE_ERASE: begin
        if (r.position == 0 || r.position > n) st = ST_RANGE;
        else held_words.delete(r.position - 1);
      end
      default: ;
    endcase
    n = held_words.size();
    res.status   = st;
    res.count    = 7'(n);
    res.is_empty = (n == 0);
    res.front_value = (n == 0) ? '0 : held_words[0];
    res.back_value  = (n == 0) ? '0 : held_words[n - 1];
    return res;
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(15))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic request_t pick_request(input int grow_pct);
    int         n;
    int         roll;
    logic [2:0] m;
    logic [6:0] p;
    n    = held_words.size();
    roll = $urandom_range(99);
    p    = 7'($urandom_range(127));
    if (roll < grow_pct) begin
      case ($urandom_range(2))
        0: m = MODE_PUSH_FRONT;
        1: m = MODE_PUSH_BACK;
        default: begin
          m = MODE_INSERT;
          p = 7'($urandom_range(n + 1, 1));
        end
      endcase
    end else if (roll < 92) begin
      case ($urandom_range(2))
        0: m = MODE_POP_FRONT;
        1: m = MODE_POP_BACK;
        default: begin
          m = MODE_ERASE;
          if (n > 0) p = 7'($urandom_range(n, 1));
        end
      endcase
    end else begin
      m = 3'($urandom_range(7));
    end
    return mk_req(m, p, pick_word());
  endfunction

  task automatic issue(input request_t req, input logic typed, input result_t want);
    result_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    predicted = apply_request(req);
    pending_results.insert(pending_results.size(), typed ? want : predicted);
  endtask

  task automatic wait_settled();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        note_error("result transfer with nothing pending");
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (result.status !== want.status)
          note_error($sformatf("status got %0d want %0d", result.status, want.status));
        if (result.front_value !== want.front_value)
          note_error($sformatf("front_value got %0d want %0d",
                               result.front_value, want.front_value));
        if (result.back_value !== want.back_value)
          note_error($sformatf("back_value got %0d want %0d",
                               result.back_value, want.back_value));
        if (result.count !== want.count)
          note_error($sformatf("count got %0d want %0d", result.count, want.count));
        if (result.is_empty !== want.is_empty)
          note_error($sformatf("is_empty got %0d want %0d", result.is_empty, want.is_empty));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int grow;
    int items;
    rst     <= 1'b1;
    start   <= 1'b0;
    request <= '0;

    // empty list after reset
    add_row(mk_req(MODE_QUERY, 7'd0, '0), 1'b1,
            mk_result(ST_OK, '0, '0, 7'd0, 1'b1));
    add_row(mk_req(MODE_POP_FRONT, 7'd0, '0), 1'b1,
            mk_result(ST_EMPTY, '0, '0, 7'd0, 1'b1));
    add_row(mk_req(MODE_POP_BACK, 7'd0, '0), 1'b1,
            mk_result(ST_EMPTY, '0, '0, 7'd0, 1'b1));
    add_row(mk_req(MODE_ERASE, 7'd1, '0), 1'b1,
            mk_result(ST_RANGE, '0, '0, 7'd0, 1'b1));
    add_row(mk_req(MODE_INSERT, 7'd0, 32'sd5), 1'b1,
            mk_result(ST_RANGE, '0, '0, 7'd0, 1'b1));
    add_row(mk_req(MODE_INSERT, 7'd2, 32'sd5), 1'b1,
            mk_result(ST_RANGE, '0, '0, 7'd0, 1'b1));
    // insert one past the end appends
    add_row(mk_req(MODE_INSERT, 7'd1, WORD_MAX), 1'b1,
            mk_result(ST_OK, WORD_MAX, WORD_MAX, 7'd1, 1'b0));
    add_row(mk_req(MODE_PUSH_FRONT, 7'd0, WORD_MIN), 1'b1,
            mk_result(ST_OK, WORD_MIN, WORD_MAX, 7'd2, 1'b0));
    add_row(mk_req(MODE_PUSH_BACK, 7'd0, '0), 1'b0, NO_RESULT);
    add_row(mk_req(MODE_INSERT, 7'd4, 32'sd123), 1'b0, NO_RESULT);
    add_row(mk_req(MODE_INSERT, 7'd2, -32'sd1), 1'b0, NO_RESULT);
    // out of range positions on a list of five
    add_row(mk_req(MODE_ERASE, 7'd0, '0), 1'b1,
            mk_result(ST_RANGE, WORD_MIN, 32'sd123, 7'd5, 1'b0));
    add_row(mk_req(MODE_ERASE, 7'd6, '0), 1'b1,
            mk_result(ST_RANGE, WORD_MIN, 32'sd123, 7'd5, 1'b0));
    add_row(mk_req(MODE_ERASE, 7'd127, '0), 1'b1,
            mk_result(ST_RANGE, WORD_MIN, 32'sd123, 7'd5, 1'b0));
    add_row(mk_req(MODE_INSERT, 7'd127, 32'sd9), 1'b1,
            mk_result(ST_RANGE, WORD_MIN, 32'sd123, 7'd5, 1'b0));
    add_row(mk_req(MODE_ERASE, 7'd5, '0), 1'b0, NO_RESULT);
    add_row(mk_req(MODE_ERASE, 7'd1, '0), 1'b0, NO_RESULT);
    add_row(mk_req(MODE_POP_FRONT, 7'd0, '0), 1'b0, NO_RESULT);
    add_row(mk_req(MODE_POP_BACK, 7'd0, '0), 1'b0, NO_RESULT);
    add_row(mk_req(MODE_UNUSED, 7'd127, '1), 1'b0, NO_RESULT);
    add_row(mk_req(MODE_QUERY, 7'd127, '1), 1'b0, NO_RESULT);
    add_row(mk_req(MODE_PUSH_BACK, 7'd85, 32'sh55555555), 1'b0, NO_RESULT);
    add_row(mk_req(MODE_PUSH_FRONT, 7'd42, 32'shaaaaaaaa), 1'b0, NO_RESULT);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

    // fill to capacity, then work the full list
    sender_idle_pct = 16;
    while (held_words.size() < CAP)
      issue(mk_req(MODE_PUSH_BACK, 7'($urandom_range(127)), pick_word()), 1'b0, NO_RESULT);
    issue(mk_req(MODE_PUSH_FRONT, 7'd0, pick_word()), 1'b0, NO_RESULT);
    issue(mk_req(MODE_PUSH_BACK, 7'd0, pick_word()), 1'b0, NO_RESULT);
    issue(mk_req(MODE_INSERT, 7'd1, pick_word()), 1'b0, NO_RESULT);
    issue(mk_req(MODE_INSERT, 7'(CAP + 1), pick_word()), 1'b0, NO_RESULT);
    issue(mk_req(MODE_INSERT, 7'(CAP + 2), pick_word()), 1'b0, NO_RESULT);
    issue(mk_req(MODE_ERASE, 7'd1, '0), 1'b0, NO_RESULT);
    issue(mk_req(MODE_INSERT, 7'd1, pick_word()), 1'b0, NO_RESULT);
    issue(mk_req(MODE_ERASE, 7'(CAP), '0), 1'b0, NO_RESULT);
    issue(mk_req(MODE_ERASE, 7'(CAP + 1), '0), 1'b0, NO_RESULT);
    issue(mk_req(MODE_INSERT, 7'(CAP), pick_word()), 1'b0, NO_RESULT);
    wait_settled();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  grow = 55; items = 150; end
        1: begin sender_idle_pct = 73; grow = 45; items = 150; end
        2: begin sender_idle_pct = 16; grow = 30; items = 150; end
        default: begin sender_idle_pct = 0; grow = 60; items = 100; end
      endcase
      repeat (items) issue(pick_request(grow), 1'b0, NO_RESULT);
    end

    wait_settled();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
